/* hdl/rtf_pkg.sv */
// ----------------------------------------------------------------------------
// rtf_pkg
// Types and constants shared by the route table forwarder and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtf_pkg;

  localparam logic [1:0] CMD_ADVERTISE = 2'd0;
  localparam logic [1:0] CMD_FRAME     = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  localparam logic [3:0] ST_STORED     = 4'd0;
  localparam logic [3:0] ST_NOT_BETTER = 4'd1;
  localparam logic [3:0] ST_SELF       = 4'd2;
  localparam logic [3:0] ST_FULL       = 4'd3;
  localparam logic [3:0] ST_DELIVERED  = 4'd4;
  localparam logic [3:0] ST_FORWARDED  = 4'd5;
  localparam logic [3:0] ST_EXPIRED    = 4'd6;
  localparam logic [3:0] ST_NOT_DATA   = 4'd7;
  localparam logic [3:0] ST_NO_ROUTE   = 4'd8;
  localparam logic [3:0] ST_REACH      = 4'd9;

  localparam logic [7:0]  OP_DATA         = 8'd1;
  localparam logic [19:0] NO_ROUTE_WEIGHT = 20'd999999;
  localparam logic [15:0] WEIGHT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] target_address;
    logic [47:0] via_mac;
    logic [15:0] via_weight;
    logic [15:0] advertised_weight;
    logic [9:0]  ttl;
    logic [7:0]  frame_operation;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [47:0] next_hop_mac;
    logic [9:0]  out_ttl;
    logic [19:0] route_weight;
  } out_item_t;

  // one table entry, shifted cell to cell on insert
  typedef struct packed {
    logic        valid;
    logic [31:0] target;
    logic [47:0] mac;
    logic [15:0] weight;
  } rtf_entry_t;

  // lookup probe, passed one cell per cycle
  typedef struct packed {
    logic        active;
    logic        upd;
    logic [31:0] target;
    logic [15:0] sum;
    logic        hit;
    logic [47:0] mac;
    logic [15:0] weight;
  } rtf_probe_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LAUNCH,
    FSM_WAIT,
    FSM_DONE
  } rtf_state_t;

endpackage

/* hdl/rtf_cell.sv */
// ----------------------------------------------------------------------------
// rtf_cell
// One routing table entry. Matches the passing probe against its target,
// improves its weight on a better advertisement, and shifts on insert.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtf_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  rtf_pkg::rtf_entry_t entry_in,
  output rtf_pkg::rtf_entry_t entry_out,
  input  rtf_pkg::rtf_probe_t probe_in,
  output rtf_pkg::rtf_probe_t probe_out
);

  logic        valid;
  logic [31:0] target;
  logic [47:0] mac;
  logic [15:0] weight;
  logic        match;
  logic        improve;

  assign match   = probe_in.active && valid && (target == probe_in.target);
  assign improve = match && probe_in.upd && (probe_in.sum < weight);

  assign entry_out.valid  = valid;
  assign entry_out.target = target;
  assign entry_out.mac    = mac;
  assign entry_out.weight = weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= entry_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      target <= entry_in.target;
      mac    <= entry_in.mac;
      weight <= entry_in.weight;
    end else if (improve) begin
      weight <= probe_in.sum;
    end
  end

  // weight passed on is the value before any update
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.active <= 1'b0;
    end else begin
      probe_out.active <= probe_in.active;
    end
    probe_out.upd    <= probe_in.upd;
    probe_out.target <= probe_in.target;
    probe_out.sum    <= probe_in.sum;
    if (match) begin
      probe_out.hit    <= 1'b1;
      probe_out.mac    <= mac;
      probe_out.weight <= weight;
    end else begin
      probe_out.hit    <= probe_in.hit;
      probe_out.mac    <= probe_in.mac;
      probe_out.weight <= probe_in.weight;
    end
  end

endmodule

/* hdl/route_table_forwarder.sv */
// ----------------------------------------------------------------------------
// route_table_forwarder
// Items decided without the table (self, expired, not data, delivered) have
//   their result registered at acceptance; a lookup sends a probe through
//   all TABLE_ENTRIES cells. One item at a time: in_ready is high only when
//   idle, after the last result is loaded out; the probe walks one cell per cycle.
// Reset (rst, synchronous) empties the table and clears own_address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module route_table_forwarder #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  rtf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rtf_pkg::out_item_t out_item
);

  rtf_pkg::rtf_state_t state, state_next;
  logic [31:0]         own_address;
  rtf_pkg::in_item_t   item;
  logic [15:0]         sum;
  rtf_pkg::out_item_t  res;
  rtf_pkg::out_item_t  imm_res;
  rtf_pkg::out_item_t  srch_res;
  logic                imm_valid;
  logic                need_search;
  logic                accept;
  logic                capture;
  logic                load_out;
  logic                shift;
  logic                full;
  logic [16:0]         sum_wide;
  logic [15:0]         sum_sat;
  rtf_pkg::rtf_entry_t new_entry;
  rtf_pkg::rtf_entry_t cell_entry [TABLE_ENTRIES];
  rtf_pkg::rtf_probe_t probe [TABLE_ENTRIES+1];
  rtf_pkg::rtf_probe_t tail;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_valid) begin
      own_address <= cfg_data;
    end
  end

  assign in_ready = (state == rtf_pkg::FSM_IDLE);
  assign accept   = in_valid && in_ready;
  assign tail     = probe[TABLE_ENTRIES];
  assign capture  = (state == rtf_pkg::FSM_WAIT) && tail.active;
  assign load_out = (state == rtf_pkg::FSM_DONE) && (!out_valid || out_ready);
  assign full     = cell_entry[TABLE_ENTRIES-1].valid;

  assign sum_wide = {1'b0, in_item.via_weight} + {1'b0, in_item.advertised_weight};
  assign sum_sat  = sum_wide[16] ? rtf_pkg::WEIGHT_MAX : sum_wide[15:0];

  // results that need no table lookup
  always_comb begin
    imm_res     = '0;
    imm_valid   = 1'b0;
    need_search = 1'b0;
    case (in_item.command)
      rtf_pkg::CMD_ADVERTISE: begin
        if (in_item.target_address == own_address) begin
          imm_res.status = rtf_pkg::ST_SELF;
          imm_valid      = 1'b1;
        end else begin
          need_search = 1'b1;
        end
      end
      rtf_pkg::CMD_FRAME: begin
        imm_valid = 1'b1;
        if (in_item.ttl <= 10'd1) begin
          imm_res.status = rtf_pkg::ST_EXPIRED;
        end else if (in_item.frame_operation != rtf_pkg::OP_DATA) begin
          imm_res.status = rtf_pkg::ST_NOT_DATA;
        end else if (in_item.target_address == own_address) begin
          imm_res.status = rtf_pkg::ST_DELIVERED;
        end else begin
          imm_valid   = 1'b0;
          need_search = 1'b1;
        end
      end
      rtf_pkg::CMD_QUERY: begin
        need_search = 1'b1;
      end
      default: begin
        imm_valid = 1'b0;
      end
    endcase
  end

  // results from the probe leaving the last cell
  always_comb begin
    srch_res = '0;
    shift    = 1'b0;
    case (item.command)
      rtf_pkg::CMD_ADVERTISE: begin
        if (tail.hit) begin
          if (sum < tail.weight) begin
            srch_res.status       = rtf_pkg::ST_STORED;
            srch_res.route_weight = {4'd0, sum};
          end else begin
            srch_res.status       = rtf_pkg::ST_NOT_BETTER;
            srch_res.route_weight = {4'd0, tail.weight};
          end
        end else if (full) begin
          srch_res.status       = rtf_pkg::ST_FULL;
          srch_res.route_weight = rtf_pkg::NO_ROUTE_WEIGHT;
        end else begin
          srch_res.status       = rtf_pkg::ST_STORED;
          srch_res.route_weight = {4'd0, sum};
          shift                 = capture;
        end
      end
      rtf_pkg::CMD_FRAME: begin
        if (tail.hit) begin
          srch_res.status       = rtf_pkg::ST_FORWARDED;
          srch_res.next_hop_mac = tail.mac;
          srch_res.out_ttl      = item.ttl - 10'd1;
        end else begin
          srch_res.status = rtf_pkg::ST_NO_ROUTE;
        end
      end
      default: begin
        srch_res.status       = rtf_pkg::ST_REACH;
        srch_res.route_weight = tail.hit ? {4'd0, tail.weight} : rtf_pkg::NO_ROUTE_WEIGHT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtf_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rtf_pkg::FSM_IDLE: begin
        if (accept && need_search) begin
          state_next = rtf_pkg::FSM_LAUNCH;
        end else if (accept && imm_valid) begin
          state_next = rtf_pkg::FSM_DONE;
        end
      end
      rtf_pkg::FSM_LAUNCH: begin
        state_next = rtf_pkg::FSM_WAIT;
      end
      rtf_pkg::FSM_WAIT: begin
        if (tail.active) begin
          state_next = rtf_pkg::FSM_DONE;
        end
      end
      rtf_pkg::FSM_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = rtf_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = rtf_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
      sum  <= sum_sat;
      res  <= imm_res;
    end else if (capture) begin
      res <= srch_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item <= res;
    end
  end

  assign probe[0].active = (state == rtf_pkg::FSM_LAUNCH);
  assign probe[0].upd    = (item.command == rtf_pkg::CMD_ADVERTISE);
  assign probe[0].target = item.target_address;
  assign probe[0].sum    = sum;
  assign probe[0].hit    = 1'b0;
  assign probe[0].mac    = '0;
  assign probe[0].weight = '0;

  assign new_entry.valid  = 1'b1;
  assign new_entry.target = item.target_address;
  assign new_entry.mac    = item.via_mac;
  assign new_entry.weight = sum;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    rtf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .entry_in  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i-1]),
      .entry_out (cell_entry[i]),
      .probe_in  (probe[i]),
      .probe_out (probe[i+1])
    );
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for route_table_forwarder. A directed table opens the
//   run: empty-table lookups, the frame check order, weight saturation, equal
//   and better routes. Random advertisements, frames and reach queries
//   follow. They draw targets from a small address pool, so routes hit, get
//   improved and fill the table past full. Four own-address settings are
//   used. Results are checked field by field, in order, against an
//   in-bench route table model. Both sides idle at random, and one long
//   output stall backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int TABLE_ENTRIES = 64;
  localparam int LOOKUP_CYCLES = TABLE_ENTRIES + 3;
  localparam int POOL_SIZE     = 96;
  localparam int PHASE_ITEMS   = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct {
    rtf_pkg::in_item_t  item;
    bit                 fixed;
    rtf_pkg::out_item_t res;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  rtf_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  rtf_pkg::out_item_t out_item;

  // route table model
  bit          rt_valid [TABLE_ENTRIES];
  logic [31:0] rt_target[TABLE_ENTRIES];
  logic [47:0] rt_mac   [TABLE_ENTRIES];
  logic [15:0] rt_weight[TABLE_ENTRIES];
  int          rt_fill;
  logic [31:0] own_addr;

  rtf_pkg::out_item_t pending_results[$];
  stim_row_t          directed_rows[$];
  logic [31:0]        addr_pool[POOL_SIZE];

  int  cycle_count;
  int  mismatch_count;
  int  results_seen;
  int  items_sent;
  int  ignored_sent;
  int  status_seen[16];
  int  idle_pct;
  bit  calm;

  route_table_forwarder #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("[%0t] result %0d: %s got %0h expected %0h", $time, results_seen, what,
               got, want);
  endtask

  task automatic route_predict(input rtf_pkg::in_item_t it, output bit has_res,
                               output rtf_pkg::out_item_t res);
    int          slot;
    int          i;
    logic [16:0] wide_sum;
    logic [15:0] sum;
    res = '0;
    has_res = 1'b1;
    slot = -1;
    for (i = 0; i < TABLE_ENTRIES; i++)
      if (slot < 0 && rt_valid[i] && rt_target[i] == it.target_address) slot = i;
    wide_sum = {1'b0, it.via_weight} + {1'b0, it.advertised_weight};
    sum = wide_sum[16] ? rtf_pkg::WEIGHT_MAX : wide_sum[15:0];
    case (it.command)
      rtf_pkg::CMD_ADVERTISE: begin
        if (it.target_address == own_addr) begin
          res.status = rtf_pkg::ST_SELF;
        end else if (slot >= 0) begin
          if (sum < rt_weight[slot]) begin
            rt_weight[slot] = sum;
            res.status = rtf_pkg::ST_STORED;
            res.route_weight = {4'd0, sum};
          end else begin
            res.status = rtf_pkg::ST_NOT_BETTER;
            res.route_weight = {4'd0, rt_weight[slot]};
          end
        end else if (rt_fill >= TABLE_ENTRIES) begin
          res.status = rtf_pkg::ST_FULL;
          res.route_weight = rtf_pkg::NO_ROUTE_WEIGHT;
        end else begin
          rt_valid[rt_fill] = 1'b1;
          rt_target[rt_fill] = it.target_address;
          rt_mac[rt_fill] = it.via_mac;
          rt_weight[rt_fill] = sum;
          rt_fill++;
          res.status = rtf_pkg::ST_STORED;
          res.route_weight = {4'd0, sum};
        end
      end
      rtf_pkg::CMD_FRAME: begin
        if (it.ttl <= 10'd1) begin
          res.status = rtf_pkg::ST_EXPIRED;
        end else if (it.frame_operation != rtf_pkg::OP_DATA) begin
          res.status = rtf_pkg::ST_NOT_DATA;
        end else if (it.target_address == own_addr) begin
          res.status = rtf_pkg::ST_DELIVERED;
        end else if (slot >= 0) begin
          res.status = rtf_pkg::ST_FORWARDED;
          res.next_hop_mac = rt_mac[slot];
          res.out_ttl = it.ttl - 10'd1;
        end else begin
          res.status = rtf_pkg::ST_NO_ROUTE;
        end
      end
      rtf_pkg::CMD_QUERY: begin
        res.status = rtf_pkg::ST_REACH;
        res.route_weight = (slot >= 0) ? {4'd0, rt_weight[slot]}
                                       : rtf_pkg::NO_ROUTE_WEIGHT;
      end
      default: has_res = 1'b0;
    endcase
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_own_address(input logic [31:0] value);
    wait_drained();
    repeat (2 * LOOKUP_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    own_addr = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic offer_item(input rtf_pkg::in_item_t it, input bit fixed,
                            input rtf_pkg::out_item_t typed);
    bit                 has_res;
    rtf_pkg::out_item_t res;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    route_predict(it, has_res, res);
    if (has_res) pending_results.push_back(fixed ? typed : res);
    else ignored_sent++;
    items_sent++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [31:0] target,
                         input logic [47:0] mac, input logic [15:0] vw,
                         input logic [15:0] aw, input logic [9:0] ttl,
                         input logic [7:0] op, input bit fixed, input logic [3:0] st,
                         input logic [47:0] omac, input logic [9:0] ottl,
                         input logic [19:0] w);
    stim_row_t row;
    row.item = '{cmd, target, mac, vw, aw, ttl, op};
    row.fixed = fixed;
    row.res = '{st, omac, ottl, w};
    directed_rows.push_back(row);
  endtask

  function automatic logic [31:0] pick_target(input int pool_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return own_addr;
    if (r < pool_pct) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'($urandom_range(0, 40));
    if (r < 50) return 16'($urandom_range(16'hC000, 16'hFFFF));
    return 16'($urandom);
  endfunction

  task automatic make_random_item(output rtf_pkg::in_item_t it);
    int          r;
    logic [63:0] mac64;
    r = $urandom_range(0, 99);
    mac64 = {$urandom, $urandom};
    it.via_mac = mac64[47:0];
    it.via_weight = pick_weight();
    it.advertised_weight = pick_weight();
    it.ttl = ($urandom_range(0, 9) < 2) ? 10'($urandom_range(0, 1)) : 10'($urandom);
    it.frame_operation = ($urandom_range(0, 99) < 80) ? rtf_pkg::OP_DATA : 8'($urandom);
    if (r < 38) begin
      it.command = rtf_pkg::CMD_ADVERTISE;
      it.target_address = pick_target(88);
    end else if (r < 72) begin
      it.command = rtf_pkg::CMD_FRAME;
      it.target_address = pick_target(85);
    end else if (r < 96) begin
      it.command = rtf_pkg::CMD_QUERY;
      it.target_address = pick_target(80);
    end else begin
      it.command = 2'd3;
      it.target_address = $urandom;
    end
  endtask

  // results leave in order; compare against the oldest prediction
  always @(posedge clk) begin : result_check
    rtf_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_item.status < 4'd10) status_seen[out_item.status]++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 64'(out_item.status), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", 64'(out_item.status), 64'(want.status));
        if (out_item.next_hop_mac !== want.next_hop_mac)
          report_mismatch("next_hop_mac", 64'(out_item.next_hop_mac),
                          64'(want.next_hop_mac));
        if (out_item.out_ttl !== want.out_ttl)
          report_mismatch("out_ttl", 64'(out_item.out_ttl), 64'(want.out_ttl));
        if (out_item.route_weight !== want.route_weight)
          report_mismatch("route_weight", 64'(out_item.route_weight),
                          64'(want.route_weight));
      end
    end
  end

  // output side: random stalls, plus one long hold to back the block up
  initial begin : result_drain
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 399) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    rtf_pkg::in_item_t it;
    logic [31:0]       own_settings[4];
    int                ph;
    int                n;
    int                i;
    bit                paused;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_item <= '0;
    mismatch_count = 0;
    results_seen = 0;
    items_sent = 0;
    ignored_sent = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (rt_valid[i]) rt_valid[i] = 1'b0;
    rt_fill = 0;
    own_addr = '0;
    idle_pct = 20;
    calm = 1'b0;
    paused = 1'b0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = 32'h1;
    addr_pool[3] = 32'hA5A5_A5A5;

    // own address is still 0 from reset
    add_row(rtf_pkg::CMD_QUERY, 32'h1234_5678, 48'h0, 16'h0, 16'h0, 10'd0, 8'd0,
            1, rtf_pkg::ST_REACH, 48'h0, 10'd0, rtf_pkg::NO_ROUTE_WEIGHT);
    add_row(rtf_pkg::CMD_FRAME, 32'h5, 48'h0, 16'h0, 16'h0, 10'd0, rtf_pkg::OP_DATA,
            1, rtf_pkg::ST_EXPIRED, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'h5, 48'h0, 16'h0, 16'h0, 10'd1, rtf_pkg::OP_DATA,
            1, rtf_pkg::ST_EXPIRED, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'h5, 48'h0, 16'h0, 16'h0, 10'd2, 8'd0,
            1, rtf_pkg::ST_NOT_DATA, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'h5, 48'h0, 16'h0, 16'h0, 10'd1023, 8'd255,
            1, rtf_pkg::ST_NOT_DATA, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'h0, 48'h0, 16'h0, 16'h0, 10'd5, rtf_pkg::OP_DATA,
            1, rtf_pkg::ST_DELIVERED, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'hFFFF_FFFF, 48'h0, 16'h0, 16'h0, 10'd5,
            rtf_pkg::OP_DATA, 1, rtf_pkg::ST_NO_ROUTE, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_ADVERTISE, 32'h0, 48'h1, 16'h1, 16'h1, 10'd0, 8'd0,
            1, rtf_pkg::ST_SELF, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_ADVERTISE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
            16'hFFFF, 10'd0, 8'd0, 1, rtf_pkg::ST_STORED, 48'h0, 10'd0, 20'd65535);
    add_row(rtf_pkg::CMD_ADVERTISE, 32'hFFFF_FFFF, 48'h0, 16'h0, 16'hFFFF, 10'd0, 8'd0,
            1, rtf_pkg::ST_NOT_BETTER, 48'h0, 10'd0, 20'd65535);
    // a better route keeps the stored next hop
    add_row(rtf_pkg::CMD_ADVERTISE, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 16'h0, 16'h0,
            10'd0, 8'd0, 1, rtf_pkg::ST_STORED, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_QUERY, 32'hFFFF_FFFF, 48'h0, 16'h0, 16'h0, 10'd0, 8'd0,
            1, rtf_pkg::ST_REACH, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'hFFFF_FFFF, 48'h0, 16'h0, 16'h0, 10'd1023,
            rtf_pkg::OP_DATA, 1, rtf_pkg::ST_FORWARDED, 48'hFFFF_FFFF_FFFF, 10'd1022,
            20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'hFFFF_FFFF, 48'h0, 16'h0, 16'h0, 10'd2,
            rtf_pkg::OP_DATA, 1, rtf_pkg::ST_FORWARDED, 48'hFFFF_FFFF_FFFF, 10'd1,
            20'd0);
    add_row(rtf_pkg::CMD_ADVERTISE, 32'h1, 48'h0, 16'h8000, 16'h7FFF, 10'd0, 8'd0,
            1, rtf_pkg::ST_STORED, 48'h0, 10'd0, 20'd65535);
    add_row(rtf_pkg::CMD_ADVERTISE, 32'h1, 48'h0, 16'h8000, 16'h8000, 10'd0, 8'd0,
            1, rtf_pkg::ST_NOT_BETTER, 48'h0, 10'd0, 20'd65535);
    add_row(rtf_pkg::CMD_ADVERTISE, 32'h1, 48'h0, 16'h1, 16'h0, 10'd0, 8'd0,
            1, rtf_pkg::ST_STORED, 48'h0, 10'd0, 20'd1);
    add_row(2'd3, 32'h1, 48'h0, 16'h0, 16'h0, 10'd5, rtf_pkg::OP_DATA,
            0, rtf_pkg::ST_STORED, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'h1, 48'h0, 16'h0, 16'h0, 10'd3, rtf_pkg::OP_DATA,
            1, rtf_pkg::ST_FORWARDED, 48'h0, 10'd2, 20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'h1, 48'h0, 16'h0, 16'h0, 10'd0, 8'd7,
            1, rtf_pkg::ST_EXPIRED, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'h0, 48'h0, 16'h0, 16'h0, 10'd2, 8'd2,
            1, rtf_pkg::ST_NOT_DATA, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_QUERY, 32'h1, 48'h0, 16'h0, 16'h0, 10'd0, 8'd0,
            1, rtf_pkg::ST_REACH, 48'h0, 10'd0, 20'd1);
    add_row(rtf_pkg::CMD_ADVERTISE, 32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A, 16'd100, 16'd23,
            10'h2AA, 8'hAA, 0, rtf_pkg::ST_STORED, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_QUERY, 32'hA5A5_A5A5, 48'h0, 16'h0, 16'h0, 10'd0, 8'd0,
            0, rtf_pkg::ST_STORED, 48'h0, 10'd0, 20'd0);
    add_row(rtf_pkg::CMD_FRAME, 32'hA5A5_A5A5, 48'h0, 16'h0, 16'h0, 10'h155,
            rtf_pkg::OP_DATA, 0, rtf_pkg::ST_STORED, 48'h0, 10'd0, 20'd0);
    add_row(2'd3, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 10'h3FF,
            8'hFF, 0, rtf_pkg::ST_STORED, 48'h0, 10'd0, 20'd0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_rows.size(); i++) begin
      offer_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].res);
      sender_gap();
    end

    own_settings[0] = 32'hFFFF_FFFF;
    own_settings[1] = addr_pool[$urandom_range(4, POOL_SIZE - 1)];
    own_settings[2] = 32'h0;
    own_settings[3] = $urandom;
    for (ph = 0; ph < 4; ph++) begin
      in_valid <= 1'b0;
      write_own_address(own_settings[ph]);
      idle_pct = (ph == 1) ? 40 : (ph == 2) ? 0 : 20;
      n = 0;
      while (n < PHASE_ITEMS) begin
        make_random_item(it);
        if (it.command != 2'd3) n++;
        offer_item(it, 1'b0, '0);
        sender_gap();
        if (ph == 1 && !paused && n >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          in_valid <= 1'b0;
          wait_drained();
        end
        if (ph == 3 && n >= PHASE_ITEMS / 2) calm = 1'b1;
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (2 * LOOKUP_CYCLES) @(posedge clk);

    $display("%0d items sent (%0d ignored), %0d results checked, table at %0d of %0d",
             items_sent, ignored_sent, results_seen, rt_fill, TABLE_ENTRIES);
    $display({"stored %0d, not better %0d, self %0d, full %0d, delivered %0d, ",
              "forwarded %0d, expired %0d, not data %0d, no route %0d, reach %0d"},
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7],
             status_seen[8], status_seen[9]);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
